/* rtl/rtmh_pkg.sv */
package rtmh_pkg;

  localparam int unsigned EntriesDefault = 16;
  localparam int unsigned PayloadBitsDefault = 32;
  localparam logic [15:0] ThresholdReset = 16'd30;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_STALE  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_REJECTED = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] dest_ip;
    logic [7:0]  hop_count;
    logic [31:0] route_payload;
    logic [31:0] route_time;
    logic [31:0] now_time;
  } req_t;

endpackage

/* rtl/rtmh_front.sv */
module rtmh_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2:0]     command,
  input  logic [31:0]    dest_ip,
  input  logic [7:0]     hop_count,
  input  logic [31:0]    route_payload,
  input  logic [31:0]    route_time,
  input  logic [31:0]    now_time,
  input  logic           pop,
  output logic           busy,
  output logic           q_valid,
  output rtmh_pkg::req_t q_req
);
  import rtmh_pkg::*;

  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  req_t       fifo [2];
  logic       push;

  assign busy = (count != 2'd0);
  assign push = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_req = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{command, dest_ip, hop_count, route_payload, route_time, now_time};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd1)
    else $error("request queue overfilled");
  assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) push |=> busy)
    else $error("busy not raised after request");

endmodule

/* rtl/rtmh_back.sv */
module rtmh_back #(
  parameter int unsigned ENTRIES = rtmh_pkg::EntriesDefault,
  parameter int unsigned PAYLOAD_BITS = rtmh_pkg::PayloadBitsDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  rtmh_pkg::req_t q_req,
  input  logic [15:0]    threshold,
  output logic           pop,
  output logic           done,
  output logic [2:0]     status,
  output logic           found,
  output logic [7:0]     out_hop_count,
  output logic [31:0]    out_payload,
  output logic [31:0]    out_time,
  output logic           stale
);
  import rtmh_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // The payload port is 32 bits wide, so no more than 32 bits are ever kept.
  localparam int unsigned PW = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SRCH  = 4'b0010,
    S_READ  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [ENTRIES-1:0]      valid;
  logic [31:0]             key_mem  [ENTRIES];
  logic [7:0]              hops_mem [ENTRIES];
  logic [PW-1:0]           pay_mem  [ENTRIES];
  logic [31:0]             time_mem [ENTRIES];

  req_t                    req;
  logic                    hit;
  logic [IW-1:0]           hit_idx;
  logic                    free_ok;
  logic [IW-1:0]           free_idx;
  logic [7:0]              rd_hops;
  logic [PW-1:0]           rd_pay;
  logic [31:0]             rd_time;
  logic                    match_any;
  logic [IW-1:0]           match_idx;
  logic                    free_any;
  logic [IW-1:0]           free_first;
  logic [31:0]             age;
  logic [31:0]             pay_ext;

  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    free_any = 1'b0;
    free_first = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && key_mem[i] == req.dest_ip) begin
        match_any = 1'b1;
        match_idx = IW'(i);
      end
      if (!valid[i]) begin
        free_any = 1'b1;
        free_first = IW'(i);
      end
    end
  end

  assign pop = (state == S_IDLE) && q_valid;
  assign age = req.now_time - rd_time;

  always_comb begin
    pay_ext = '0;
    pay_ext[PW-1:0] = rd_pay;
  end

  always_comb begin
    case (state)
      S_IDLE:  state_next = q_valid ? S_SRCH : S_IDLE;
      S_SRCH:  state_next = S_READ;
      S_READ:  state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (state == S_EXEC) begin
        done <= 1'b1;
        case (req.command)
          CMD_ADD:    if (!hit && free_ok) valid[free_idx] <= 1'b1;
          CMD_DELETE: if (hit) valid[hit_idx] <= 1'b0;
          CMD_CLEAR:  valid <= '0;
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) req <= q_req;
    if (state == S_SRCH) begin
      hit <= match_any;
      hit_idx <= match_idx;
      free_ok <= free_any;
      free_idx <= free_first;
    end
    if (state == S_READ) begin
      rd_hops <= hops_mem[hit_idx];
      rd_pay <= pay_mem[hit_idx];
      rd_time <= time_mem[hit_idx];
    end
    if (state == S_EXEC) begin
      status <= ST_DONE;
      found <= 1'b0;
      out_hop_count <= '0;
      out_payload <= '0;
      out_time <= '0;
      stale <= 1'b0;
      case (req.command)
        CMD_ADD: begin
          if (hit) begin
            found <= 1'b1;
            if (req.hop_count < rd_hops) begin
              status <= ST_UPDATED;
              hops_mem[hit_idx] <= req.hop_count;
              pay_mem[hit_idx] <= req.route_payload[PW-1:0];
              time_mem[hit_idx] <= req.route_time;
            end else begin
              status <= ST_REJECTED;
            end
          end else if (!free_ok) begin
            status <= ST_FULL;
          end else begin
            key_mem[free_idx] <= req.dest_ip;
            hops_mem[free_idx] <= req.hop_count;
            pay_mem[free_idx] <= req.route_payload[PW-1:0];
            time_mem[free_idx] <= req.route_time;
          end
        end
        CMD_LOOKUP, CMD_STALE: begin
          if (!hit) begin
            status <= ST_NOTFOUND;
          end else begin
            found <= 1'b1;
            out_hop_count <= rd_hops;
            out_payload <= pay_ext;
            out_time <= rd_time;
            stale <= (req.command == CMD_STALE) && (age >= {16'd0, threshold});
          end
        end
        CMD_DELETE: begin
          if (hit) found <= 1'b1;
          else status <= ST_NOTFOUND;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(state) == S_EXEC)
    else $error("result without execute step");
  assert property (@(posedge clk) disable iff (rst) pop |=> state == S_SRCH)
    else $error("search did not follow pop");
  assert property (@(posedge clk) disable iff (rst)
      (state == S_EXEC && req.command == CMD_CLEAR) |=> valid == '0)
    else $error("clear left valid slots");

endmodule

/* rtl/route_table_min_hop.sv */
// Route table keyed by destination address with minimum-hop replacement.
// Requests enter on start with command, dest_ip, hop_count, route_payload,
// route_time and now_time; a request is taken when start is high and busy low.
// A one-entry-deep queue holds the request until the table engine takes it.
// The engine takes each request through pop, parallel key and free-slot
// search, table read, then execute and write back. The result appears on
// status, found, out_hop_count, out_payload, out_time and stale, marked by
// done, which is high for exactly one cycle.
// busy is high only while the queue holds a request, so a second request can
// wait in the queue while the engine works on the first; the engine takes
// the next request only once it has finished the one before.
// The receiver cannot stall, so results are never held back.
// stale_threshold is written over the APB port at address 0.
// Reset clears every valid bit at once and restores the threshold to 30.
module route_table_min_hop #(
  parameter int unsigned ENTRIES = rtmh_pkg::EntriesDefault,
  parameter int unsigned PAYLOAD_BITS = rtmh_pkg::PayloadBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [31:0] dest_ip,
  input  logic [7:0]  hop_count,
  input  logic [31:0] route_payload,
  input  logic [31:0] route_time,
  input  logic [31:0] now_time,
  output logic        done,
  output logic [2:0]  status,
  output logic        found,
  output logic [7:0]  out_hop_count,
  output logic [31:0] out_payload,
  output logic [31:0] out_time,
  output logic        stale,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rtmh_pkg::*;

  logic [15:0] threshold;
  logic        q_valid;
  req_t        q_req;
  logic        pop;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ThresholdReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      threshold <= pwdata[15:0];
    end
  end

  rtmh_front u_front (
    .clk, .rst, .start, .command, .dest_ip, .hop_count, .route_payload,
    .route_time, .now_time, .pop, .busy, .q_valid, .q_req
  );

  rtmh_back #(.ENTRIES(ENTRIES), .PAYLOAD_BITS(PAYLOAD_BITS)) u_back (
    .clk, .rst, .q_valid, .q_req, .threshold, .pop, .done, .status, .found,
    .out_hop_count, .out_payload, .out_time, .stale
  );

endmodule

/* tb/route_table_min_hop_tb.sv */
module route_table_min_hop_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtmh_pkg::*;

  localparam int Slots = 16;
  localparam int WatchLimit = 4000;
  localparam int SettleCycles = 12;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [7:0]  hops;
    logic [31:0] payload;
    logic [31:0] stamp;
    logic        stale;
  } route_res_t;

  typedef struct {
    req_t       rq;
    bit         typed;
    route_res_t rs;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  command = '0;
  logic [31:0] dest_ip = '0;
  logic [7:0]  hop_count = '0;
  logic [31:0] route_payload = '0;
  logic [31:0] route_time = '0;
  logic [31:0] now_time = '0;
  logic        done;
  logic [2:0]  status;
  logic        found;
  logic [7:0]  out_hop_count;
  logic [31:0] out_payload;
  logic [31:0] out_time;
  logic        stale;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  route_table_min_hop dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Private copy of the table.
  logic        tbl_valid [Slots];
  logic [31:0] tbl_key [Slots];
  logic [7:0]  tbl_hops [Slots];
  logic [31:0] tbl_payload [Slots];
  logic [31:0] tbl_stamp [Slots];
  logic [15:0] age_limit;

  route_res_t pending_results[$];
  logic [31:0] key_pool[$];
  int fail_count = 0;
  int request_count = 0;
  int result_count = 0;
  int stale_hits = 0;
  int full_hits = 0;
  int idle_cycles = 0;
  bit burst = 1'b0;

  function automatic int key_slot(logic [31:0] key);
    for (int i = 0; i < Slots; i++) begin
      if (tbl_valid[i] && tbl_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic route_res_t route_predict(req_t r);
    route_res_t res;
    int idx;
    logic [31:0] age;
    res = '0;
    idx = key_slot(r.dest_ip);
    case (r.command)
      CMD_ADD: begin
        if (idx >= 0) begin
          res.found = 1'b1;
          if (r.hop_count < tbl_hops[idx]) begin
            tbl_hops[idx] = r.hop_count;
            tbl_payload[idx] = r.route_payload;
            tbl_stamp[idx] = r.route_time;
            res.status = ST_UPDATED;
          end else begin
            res.status = ST_REJECTED;
          end
        end else begin
          res.status = ST_FULL;
          for (int i = 0; i < Slots; i++) begin
            if (!tbl_valid[i]) begin
              tbl_valid[i] = 1'b1;
              tbl_key[i] = r.dest_ip;
              tbl_hops[i] = r.hop_count;
              tbl_payload[i] = r.route_payload;
              tbl_stamp[i] = r.route_time;
              res.status = ST_DONE;
              break;
            end
          end
        end
      end
      CMD_LOOKUP, CMD_STALE: begin
        if (idx < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          res.found = 1'b1;
          res.hops = tbl_hops[idx];
          res.payload = tbl_payload[idx];
          res.stamp = tbl_stamp[idx];
          if (r.command == CMD_STALE) begin
            age = r.now_time - tbl_stamp[idx];
            res.stale = (age >= {16'd0, age_limit});
          end
        end
      end
      CMD_DELETE: begin
        if (idx < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          res.found = 1'b1;
          tbl_valid[idx] = 1'b0;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < Slots; i++) tbl_valid[i] = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic req_t mk(logic [2:0] c, logic [31:0] ip, logic [7:0] h,
                              logic [31:0] p, logic [31:0] t, logic [31:0] n);
    req_t r;
    r.command = c;
    r.dest_ip = ip;
    r.hop_count = h;
    r.route_payload = p;
    r.route_time = t;
    r.now_time = n;
    return r;
  endfunction

  function automatic route_res_t mkres(logic [2:0] s, logic f, logic [7:0] h,
                                       logic [31:0] p, logic [31:0] t, logic st);
    return {s, f, h, p, t, st};
  endfunction

  task automatic send_request(req_t r, bit typed, route_res_t typed_res);
    int gap;
    route_res_t predicted;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= r.command;
    dest_ip <= r.dest_ip;
    hop_count <= r.hop_count;
    route_payload <= r.route_payload;
    route_time <= r.route_time;
    now_time <= r.now_time;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = route_predict(r);
    if (predicted.stale) stale_hits++;
    if (predicted.status == ST_FULL) full_hits++;
    pending_results.push_back(typed ? typed_res : predicted);
    request_count++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_age_limit(logic [15:0] value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 2'd0;
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    age_limit = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== value) begin
      $error("stale_threshold readback: expected %0d, got %0d", value, prdata[15:0]);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic req_t random_request();
    req_t r;
    int pick;
    int idx;
    r.dest_ip = ($urandom_range(0, 9) == 0) ? $urandom() :
                key_pool[$urandom_range(0, key_pool.size() - 1)];
    r.hop_count = 8'($urandom());
    r.route_payload = $urandom();
    r.route_time = $urandom();
    r.now_time = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 40) r.command = CMD_ADD;
    else if (pick < 60) r.command = CMD_LOOKUP;
    else if (pick < 75) r.command = CMD_DELETE;
    else if (pick < 94) r.command = CMD_STALE;
    else if (pick < 96) r.command = CMD_CLEAR;
    else r.command = 3'($urandom_range(5, 7));
    idx = key_slot(r.dest_ip);
    if (r.command == CMD_STALE && idx >= 0 && $urandom_range(0, 3) != 0)
      r.now_time = tbl_stamp[idx] + {16'd0, age_limit} + 32'($urandom_range(0, 4)) - 32'd2;
    return r;
  endfunction

  always @(posedge clk) begin
    route_res_t exp_res;
    if (!rst && done) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, status);
          fail_count++;
        end
        if (found !== exp_res.found) begin
          $error("found: expected %0d, got %0d", exp_res.found, found);
          fail_count++;
        end
        if (out_hop_count !== exp_res.hops) begin
          $error("out_hop_count: expected %0d, got %0d", exp_res.hops, out_hop_count);
          fail_count++;
        end
        if (out_payload !== exp_res.payload) begin
          $error("out_payload: expected %h, got %h", exp_res.payload, out_payload);
          fail_count++;
        end
        if (out_time !== exp_res.stamp) begin
          $error("out_time: expected %h, got %h", exp_res.stamp, out_time);
          fail_count++;
        end
        if (stale !== exp_res.stale) begin
          $error("stale: expected %0d, got %0d", exp_res.stale, stale);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("route_table_min_hop test failed");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    logic [15:0] limits[4];
    for (int i = 0; i < Slots; i++) tbl_valid[i] = 1'b0;
    age_limit = ThresholdReset;
    for (int i = 0; i < 24; i++) key_pool.push_back($urandom());
    key_pool.push_back(32'd0);
    key_pool.push_back(32'hFFFF_FFFF);

    row.typed = 1'b1;
    row.rq = mk(CMD_LOOKUP, 32'h0A00_0001, 8'd0, '0, '0, '0);
    row.rs = mkres(ST_NOTFOUND, 0, 0, 0, 0, 0); rows.push_back(row);
    row.rq = mk(CMD_STALE, 32'h0A00_0001, 8'd0, '0, '0, '1);
    rows.push_back(row);
    row.rq = mk(CMD_DELETE, 32'h0A00_0001, 8'd0, '0, '0, '0);
    rows.push_back(row);
    row.rq = mk(CMD_ADD, 32'd0, 8'd0, 32'd0, 32'd0, 32'd0);
    row.rs = mkres(ST_DONE, 0, 0, 0, 0, 0); rows.push_back(row);
    row.rq = mk(CMD_ADD, '1, 8'hFF, '1, '1, '1);
    rows.push_back(row);
    row.rq = mk(CMD_LOOKUP, '1, 8'd0, '0, '0, '0);
    row.rs = mkres(ST_DONE, 1, 8'hFF, '1, '1, 0); rows.push_back(row);
    row.rq = mk(CMD_ADD, '1, 8'hFF, 32'h1234_5678, 32'd5, '0);
    row.rs = mkres(ST_REJECTED, 1, 0, 0, 0, 0); rows.push_back(row);
    row.rq = mk(CMD_ADD, 32'd0, 8'd0, 32'h1, 32'h1, '0);
    rows.push_back(row);
    row.rq = mk(CMD_ADD, '1, 8'hFE, 32'h1234_5678, 32'd100, '0);
    row.rs = mkres(ST_UPDATED, 1, 0, 0, 0, 0); rows.push_back(row);
    row.rq = mk(CMD_STALE, '1, 8'd0, '0, '0, 32'd100);
    row.rs = mkres(ST_DONE, 1, 8'hFE, 32'h1234_5678, 32'd100, 0); rows.push_back(row);
    row.rq = mk(CMD_STALE, '1, 8'd0, '0, '0, 32'd130);
    row.rs = mkres(ST_DONE, 1, 8'hFE, 32'h1234_5678, 32'd100, 1); rows.push_back(row);
    row.typed = 1'b0;
    row.rq = mk(CMD_STALE, '1, 8'd0, '0, '0, 32'd129); rows.push_back(row);
    row.rq = mk(CMD_STALE, '1, 8'd0, '0, '0, 32'd99); rows.push_back(row);
    row.rq = mk(CMD_STALE, 32'd0, 8'd0, '0, '0, '1); rows.push_back(row);
    row.typed = 1'b1;
    row.rq = mk(CMD_DELETE, 32'd0, 8'd0, '0, '0, '0);
    row.rs = mkres(ST_DONE, 1, 0, 0, 0, 0); rows.push_back(row);
    row.rq = mk(CMD_LOOKUP, 32'd0, 8'd0, '0, '0, '0);
    row.rs = mkres(ST_NOTFOUND, 0, 0, 0, 0, 0); rows.push_back(row);
    row.rq = mk(3'd7, '1, 8'hFF, '1, '1, '1);
    row.rs = '0; rows.push_back(row);
    row.rq = mk(3'd5, '1, 8'hFF, '1, '1, '1); rows.push_back(row);
    row.rq = mk(3'd6, '0, 8'h00, '0, '0, '0); rows.push_back(row);
    row.rq = mk(CMD_CLEAR, '1, 8'hFF, '1, '1, '1); rows.push_back(row);
    row.rq = mk(CMD_LOOKUP, '1, 8'd0, '0, '0, '0);
    row.rs = mkres(ST_NOTFOUND, 0, 0, 0, 0, 0); rows.push_back(row);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_request(rows[i].rq, rows[i].typed, rows[i].rs);
    // Fill the table, then offer two more new keys.
    for (int i = 0; i <= Slots; i++)
      send_request(mk(CMD_ADD, 32'hC0A8_0000 + i, 8'(i), $urandom(), $urandom(), '0),
                   1'b0, '0);
    send_request(mk(CMD_ADD, 32'h0101_0101, 8'd1, '0, '0, '0), 1'b1,
                 mkres(ST_FULL, 0, 0, 0, 0, 0));

    limits[0] = 16'd0;
    limits[1] = 16'hFFFF;
    limits[2] = 16'($urandom());
    limits[3] = 16'd1;
    for (int ph = 0; ph < 4; ph++) begin
      set_age_limit(limits[ph]);
      for (int n = 0; n < 455; n++) begin
        if (n % 60 == 0) burst = ($urandom_range(0, 2) == 0);
        send_request(random_request(), 1'b0, '0);
      end
      burst = 1'b0;
    end

    drain();
    $display("Ran %0d requests and checked %0d results over four threshold settings.",
             request_count, result_count);
    $display("Saw %0d stale verdicts and %0d table-full rejections.", stale_hits, full_hits);
    if (fail_count == 0) begin
      $display("route_table_min_hop test passed");
    end else begin
      $display("route_table_min_hop test failed");
    end
    $finish;
  end

endmodule
